### src/slt_pkg.sv
package slt_pkg;

    localparam int ELEM_W = 32;
    localparam int INTER_W = 11;
    localparam int UNION_W = 12;
    localparam int RATIO_W = 17;

    typedef enum logic [1:0] {
        REQ_APPEND_A = 2'd0,
        REQ_APPEND_B = 2'd1,
        REQ_COMPARE  = 2'd2,
        REQ_NONE     = 2'd3
    } req_kind_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_INIT,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_SORT_NEXT,
        ST_MERGE_RD,
        ST_MERGE_CMP,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

### src/slt_req_if.sv
interface slt_req_if;
    import slt_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [ELEM_W-1:0] element_value;
    modport source (output valid, req_type, element_value, input ready);
    modport sink (input valid, req_type, element_value, output ready);
endinterface

### src/slt_res_if.sv
interface slt_res_if;
    import slt_pkg::*;
    logic               valid;
    logic               ready;
    logic [INTER_W-1:0] intersection_count;
    logic [UNION_W-1:0] union_count;
    logic [RATIO_W-1:0] similarity_q16;
    logic               both_empty;
    logic               overflowed;
    modport source (output valid, intersection_count, union_count, similarity_q16,
                    both_empty, overflowed, input ready);
    modport sink (input valid, intersection_count, union_count, similarity_q16,
                  both_empty, overflowed, output ready);
endinterface

### src/sorted_list_tanimoto.sv
// Tanimoto similarity of two descriptor lists. Append requests (0 first list,
// 1 second list) are taken one per cycle while no compare is in progress and
// write the list memory directly; appends beyond MAX_LEN are dropped and
// flagged. A compare request (2) stalls the input: unless presorted is 1, each
// list is insertion sorted in place, then a merge walk counts the common and
// total elements, then a restoring divider forms the ratio (zero when both
// lists are empty). The result waits in an output register; both lists and the
// drop flag are cleared by each compare.
module sorted_list_tanimoto
    import slt_pkg::*;
#(
    parameter int MAX_LEN = 1024
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_we,
    input  logic    cfg_wdata,
    slt_req_if.sink req,
    slt_res_if.source res
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int JW = LW + 1;

    state_t state_reg, state_next;
    logic presorted_reg;
    logic [LW-1:0] len_a_reg, len_b_reg;
    logic drop_reg;
    logic side_reg;
    logic [LW-1:0] k_reg, pos_reg, ia_reg, ib_reg;
    logic [ELEM_W-1:0] key_reg;
    logic [JW-1:0] meet_reg, join_reg;
    logic [RATIO_W-1:0] quo_reg;
    logic [JW:0] rem_reg;
    logic [4:0] bit_reg;
    logic res_valid_reg;
    logic [INTER_W-1:0] res_meet_reg;
    logic [UNION_W-1:0] res_join_reg;
    logic [RATIO_W-1:0] res_ratio_reg;
    logic res_empty_reg, res_drop_reg;

    logic we_a, we_b;
    logic [AW-1:0] wa_a, wa_b, ra_a, ra_b;
    logic [ELEM_W-1:0] wd_a, wd_b, rd_a, rd_b;

    slt_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_LEN)) u_ram_a (
        .clk(clk), .we(we_a), .waddr(wa_a), .wdata(wd_a), .raddr(ra_a), .rdata(rd_a));
    slt_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_LEN)) u_ram_b (
        .clk(clk), .we(we_b), .waddr(wa_b), .wdata(wd_b), .raddr(ra_b), .rdata(rd_b));

    logic accept;
    logic [LW-1:0] cur_len;
    logic [ELEM_W-1:0] rd_cur;
    logic [JW:0] rem_shift;
    logic [JW:0] join_ext;

    assign req.ready = (state_reg == ST_LOAD);
    assign accept = req.valid && req.ready;
    assign cur_len = side_reg ? len_b_reg : len_a_reg;
    assign rd_cur = side_reg ? rd_b : rd_a;
    assign join_ext = {1'b0, join_reg};
    assign rem_shift = {rem_reg[JW-1:0], quo_reg[RATIO_W-1]};

    assign res.valid = res_valid_reg;
    assign res.intersection_count = res_meet_reg;
    assign res.union_count = res_join_reg;
    assign res.similarity_q16 = res_ratio_reg;
    assign res.both_empty = res_empty_reg;
    assign res.overflowed = res_drop_reg;

    always_comb
    begin
        state_next = state_reg;
        we_a = 1'b0;
        we_b = 1'b0;
        wa_a = AW'(len_a_reg);
        wa_b = AW'(len_b_reg);
        wd_a = req.element_value;
        wd_b = req.element_value;
        ra_a = '0;
        ra_b = '0;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept && req.req_type == REQ_APPEND_A && len_a_reg < LW'(MAX_LEN))
                begin
                    we_a = 1'b1;
                end
                if (accept && req.req_type == REQ_APPEND_B && len_b_reg < LW'(MAX_LEN))
                begin
                    we_b = 1'b1;
                end
                if (accept && req.req_type == REQ_COMPARE)
                begin
                    state_next = presorted_reg ? ST_MERGE_RD : ST_SORT_INIT;
                end
            end
            ST_SORT_INIT:
            begin
                // read key at k
                ra_a = AW'(k_reg);
                ra_b = AW'(k_reg);
                if (k_reg >= cur_len)
                begin
                    state_next = side_reg ? ST_MERGE_RD : ST_SORT_INIT;
                end
                else
                begin
                    state_next = ST_SORT_RD;
                end
            end
            ST_SORT_RD:
            begin
                // key arrives; read element at pos-1
                ra_a = AW'(pos_reg - 1'b1);
                ra_b = AW'(pos_reg - 1'b1);
                state_next = ST_SORT_CMP;
            end
            ST_SORT_CMP:
            begin
                wa_a = AW'(pos_reg);
                wa_b = AW'(pos_reg);
                ra_a = AW'(pos_reg - 2'd2);
                ra_b = AW'(pos_reg - 2'd2);
                if (pos_reg != '0 && rd_cur > key_reg)
                begin
                    wd_a = rd_cur;
                    wd_b = rd_cur;
                    we_a = !side_reg;
                    we_b = side_reg;
                    state_next = ST_SORT_NEXT;
                end
                else
                begin
                    wd_a = key_reg;
                    wd_b = key_reg;
                    we_a = !side_reg;
                    we_b = side_reg;
                    state_next = ST_SORT_INIT;
                end
            end
            ST_SORT_NEXT:
            begin
                ra_a = AW'(pos_reg - 1'b1);
                ra_b = AW'(pos_reg - 1'b1);
                state_next = ST_SORT_CMP;
            end
            ST_MERGE_RD:
            begin
                ra_a = AW'(ia_reg);
                ra_b = AW'(ib_reg);
                if (ia_reg >= len_a_reg || ib_reg >= len_b_reg)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_MERGE_CMP;
                end
            end
            ST_MERGE_CMP:
            begin
                state_next = ST_MERGE_RD;
            end
            ST_DIV:
            begin
                if (join_reg == '0 || bit_reg == 5'd0)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            presorted_reg <= 1'b0;
            len_a_reg <= '0;
            len_b_reg <= '0;
            drop_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            side_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                presorted_reg <= cfg_wdata;
            end
            if (state_reg == ST_OUT && (!res_valid_reg || res.ready))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (accept && req.req_type == REQ_APPEND_A)
                    begin
                        if (len_a_reg < LW'(MAX_LEN))
                        begin
                            len_a_reg <= len_a_reg + 1'b1;
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                        end
                    end
                    if (accept && req.req_type == REQ_APPEND_B)
                    begin
                        if (len_b_reg < LW'(MAX_LEN))
                        begin
                            len_b_reg <= len_b_reg + 1'b1;
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                        end
                    end
                    side_reg <= 1'b0;
                end
                ST_SORT_INIT:
                begin
                    if (k_reg >= cur_len)
                    begin
                        side_reg <= 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (!res_valid_reg || res.ready)
                    begin
                        len_a_reg <= '0;
                        len_b_reg <= '0;
                        drop_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_LOAD:
            begin
                k_reg <= LW'(1);
                ia_reg <= '0;
                ib_reg <= '0;
                meet_reg <= '0;
                join_reg <= '0;
            end
            ST_SORT_INIT:
            begin
                pos_reg <= k_reg;
                if (k_reg >= cur_len)
                begin
                    k_reg <= LW'(1);
                end
            end
            ST_SORT_RD:
            begin
                key_reg <= rd_cur;
            end
            ST_SORT_CMP:
            begin
                if (pos_reg != '0 && rd_cur > key_reg)
                begin
                    pos_reg <= pos_reg - 1'b1;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            ST_MERGE_RD:
            begin
                if (ia_reg >= len_a_reg || ib_reg >= len_b_reg)
                begin
                    join_reg <= join_reg + JW'(len_a_reg - ia_reg) + JW'(len_b_reg - ib_reg);
                    // upper dividend bits give zero quotient bits, start with them
                    quo_reg <= RATIO_W'(meet_reg) << 16;
                    rem_reg <= {1'b0, meet_reg >> 1};
                    bit_reg <= 5'(RATIO_W);
                end
            end
            ST_MERGE_CMP:
            begin
                join_reg <= join_reg + 1'b1;
                if (rd_a == rd_b)
                begin
                    meet_reg <= meet_reg + 1'b1;
                    ia_reg <= ia_reg + 1'b1;
                    ib_reg <= ib_reg + 1'b1;
                end
                else if (rd_a < rd_b)
                begin
                    ia_reg <= ia_reg + 1'b1;
                end
                else
                begin
                    ib_reg <= ib_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                if (join_reg == '0)
                begin
                    quo_reg <= '0;
                end
                else if (bit_reg != 5'd0)
                begin
                    bit_reg <= bit_reg - 1'b1;
                    if (rem_shift >= join_ext)
                    begin
                        rem_reg <= rem_shift - join_ext;
                        quo_reg <= {quo_reg[RATIO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift;
                        quo_reg <= {quo_reg[RATIO_W-2:0], 1'b0};
                    end
                end
            end
            ST_OUT:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_meet_reg <= INTER_W'(meet_reg);
                    res_join_reg <= UNION_W'(join_reg);
                    res_ratio_reg <= quo_reg;
                    res_empty_reg <= (join_reg == '0);
                    res_drop_reg <= drop_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

### src/slt_ram.sv
module slt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/slt_checker.sv
module slt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic [1:0]  req_type,
    input logic        res_valid,
    input logic        res_ready,
    input logic [10:0] intersection_count,
    input logic [11:0] union_count,
    input logic [16:0] similarity_q16,
    input logic        both_empty
);

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (both_empty == (union_count == 12'd0)))
        else $error("empty flag mismatch");

    a_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && both_empty |-> similarity_q16 == 17'd0 && intersection_count == 11'd0)
        else $error("empty result not zero");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type == 2'd2 |=> !req_ready)
        else $error("compare did not stall input");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(similarity_q16))
        else $error("result dropped");

endmodule

bind sorted_list_tanimoto slt_checker u_slt_checker (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready), .req_type(req.req_type),
    .res_valid(res.valid), .res_ready(res.ready),
    .intersection_count(res.intersection_count), .union_count(res.union_count),
    .similarity_q16(res.similarity_q16), .both_empty(res.both_empty)
);

### sim/tb_sorted_list_tanimoto.sv
`timescale 1ns / 100ps

module tb_sorted_list_tanimoto;
    import slt_pkg::*;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ELEM_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic [INTER_W-1:0] meet;
        logic [UNION_W-1:0] join_cnt;
        logic [RATIO_W-1:0] ratio;
        logic               empty;
        logic               dropped;
    } similarity_t;

    localparam int LIST_CAP = 1024;
    localparam int IDLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    slt_req_if req_bus ();
    slt_res_if res_bus ();

    sorted_list_tanimoto #(.MAX_LEN(LIST_CAP)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_bus.sink),
        .res       (res_bus.source)
    );

    request_t    pending_requests[$];
    similarity_t expected_scores[$];

    logic [ELEM_W-1:0] list_a[$];
    logic [ELEM_W-1:0] list_b[$];
    logic              drop_seen;
    logic              presorted_mode;
    logic              stimulus_done;
    int                errors;
    int                gap_left;
    int                stall_left;
    int                idle_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 40);
    endfunction

    // compute the expected score of the current lists, then clear them
    function automatic similarity_t score_lists();
        similarity_t s;
        logic [ELEM_W-1:0] a[$];
        logic [ELEM_W-1:0] b[$];
        int ia;
        int ib;
        longint meet;
        longint join_cnt;
        longint ratio;
        a = list_a;
        b = list_b;
        if (!presorted_mode)
        begin
            a.sort();
            b.sort();
        end
        ia = 0;
        ib = 0;
        meet = 0;
        join_cnt = 0;
        ratio = 0;
        while (ia < a.size() && ib < b.size())
        begin
            if (a[ia] == b[ib])
            begin
                meet++;
                ia++;
                ib++;
            end
            else if (a[ia] < b[ib])
                ia++;
            else
                ib++;
            join_cnt++;
        end
        join_cnt += (a.size() - ia) + (b.size() - ib);
        if (join_cnt != 0)
            ratio = (meet << 16) / join_cnt;
        s.meet = meet[INTER_W-1:0];
        s.join_cnt = join_cnt[UNION_W-1:0];
        s.ratio = ratio[RATIO_W-1:0];
        s.empty = (join_cnt == 0);
        s.dropped = drop_seen;
        list_a.delete();
        list_b.delete();
        drop_seen = 1'b0;
        return s;
    endfunction

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
            req_bus.req_type <= REQ_NONE;
            req_bus.element_value <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (!req_bus.valid || req_bus.ready)
            begin
                if (gap_left > 0 || pending_requests.size() == 0)
                begin
                    req_bus.valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    req_bus.valid <= 1'b1;
                    req_bus.req_type <= pending_requests[0].kind;
                    req_bus.element_value <= pending_requests[0].value;
                    void'(pending_requests.pop_front());
                    gap_left <= pick_gap();
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            res_bus.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            res_bus.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // predictor fed by accepted requests, monitor on results
    always @(posedge clk)
    begin
        similarity_t got;
        similarity_t want;
        bit          moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (req_bus.valid && req_bus.ready)
            begin
                moved = 1'b1;
                case (req_kind_t'(req_bus.req_type))
                    REQ_APPEND_A:
                        if (list_a.size() < LIST_CAP)
                            list_a.push_back(req_bus.element_value);
                        else
                            drop_seen = 1'b1;
                    REQ_APPEND_B:
                        if (list_b.size() < LIST_CAP)
                            list_b.push_back(req_bus.element_value);
                        else
                            drop_seen = 1'b1;
                    REQ_COMPARE:
                        expected_scores.push_back(score_lists());
                    default:
                        ;
                endcase
            end
            if (res_bus.valid && res_bus.ready)
            begin
                moved = 1'b1;
                got.meet = res_bus.intersection_count;
                got.join_cnt = res_bus.union_count;
                got.ratio = res_bus.similarity_q16;
                got.empty = res_bus.both_empty;
                got.dropped = res_bus.overflowed;
                if (expected_scores.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %p", $time, got);
                end
                else
                begin
                    want = expected_scores.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: expected %p actual %p", $time, want, got);
                    end
                end
            end
            if (moved)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("sorted_list_tanimoto verification failed");
                $finish;
            end
        end
    end

    task automatic push_req(input logic [1:0] kind, input logic [ELEM_W-1:0] value);
        request_t r;
        r.kind = kind;
        r.value = value;
        pending_requests.push_back(r);
    endtask

    task automatic push_pair(input int len_a, input int len_b, input bit ascending,
                             input int span);
        logic [ELEM_W-1:0] v;
        int i;
        v = $urandom_range(0, 20);
        for (i = 0; i < len_a; i++)
        begin
            v = ascending ? v + $urandom_range(0, 2) : $urandom_range(0, span);
            push_req(REQ_APPEND_A, v);
        end
        v = $urandom_range(0, 20);
        for (i = 0; i < len_b; i++)
        begin
            v = ascending ? v + $urandom_range(0, 2) : $urandom_range(0, span);
            push_req(REQ_APPEND_B, v);
        end
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || req_bus.valid || expected_scores.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_presorted(input logic mode);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we <= 1'b0;
        presorted_mode = mode;
    endtask

    task automatic random_phase(input int count, input bit ascending);
        int sent;
        int la;
        int lb;
        sent = 0;
        while (sent < count)
        begin
            la = $urandom_range(0, 12);
            lb = $urandom_range(0, 12);
            if ($urandom_range(0, 9) == 0)
                push_req(REQ_NONE, $urandom());
            if ($urandom_range(0, 4) == 0)
                push_pair(la, lb, 1'b0, 32'hFFFF_FFFF);
            else
                push_pair(la, lb, ascending, 15);
            push_req(REQ_COMPARE, $urandom());
            sent += la + lb + 1;
        end
    endtask

    initial
    begin
        int i;
        errors = 0;
        idle_cycles = 0;
        drop_seen = 1'b0;
        presorted_mode = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        push_req(REQ_COMPARE, '0);
        push_req(REQ_APPEND_A, 32'hFFFF_FFFF);
        push_req(REQ_APPEND_A, 32'h0);
        push_req(REQ_APPEND_B, 32'hFFFF_FFFF);
        push_req(REQ_APPEND_B, 32'h5555_5555);
        push_req(REQ_APPEND_B, 32'hAAAA_AAAA);
        push_req(REQ_NONE, 32'h1234_5678);
        push_req(REQ_COMPARE, 32'hFFFF_FFFF);
        push_req(REQ_APPEND_A, 32'd7);
        push_req(REQ_APPEND_A, 32'd7);
        push_req(REQ_APPEND_B, 32'd7);
        push_req(REQ_COMPARE, '0);
        push_req(REQ_APPEND_B, 32'd3);
        push_req(REQ_COMPARE, '0);
        drain();

        set_presorted(1'b1);
        push_req(REQ_APPEND_A, 32'd9);
        push_req(REQ_APPEND_A, 32'd1);
        push_req(REQ_APPEND_B, 32'd1);
        push_req(REQ_APPEND_B, 32'd9);
        push_req(REQ_COMPARE, '0);
        // full list, already ascending so no sort cost
        for (i = 0; i < LIST_CAP + 3; i++)
            push_req(REQ_APPEND_A, i);
        push_req(REQ_APPEND_B, 32'd5);
        push_req(REQ_COMPARE, '0);
        drain();
        random_phase(150, 1'b1);
        drain();

        set_presorted(1'b0);
        random_phase(200, 1'b0);
        drain();

        set_presorted(1'b1);
        random_phase(100, 1'b1);
        drain();

        set_presorted(1'b0);
        random_phase(150, 1'b0);
        drain();

        if (errors == 0)
            $display("sorted_list_tanimoto verification clean");
        else
            $display("sorted_list_tanimoto verification failed");
        $finish;
    end

endmodule

### sim.f
src/slt_pkg.sv
src/slt_req_if.sv
src/slt_res_if.sv
src/slt_ram.sv
src/sorted_list_tanimoto.sv
src/slt_checker.sv
sim/tb_sorted_list_tanimoto.sv
